### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled by an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A true antecedent implies the consequent in the same cycle.
`define ADQ_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// A true antecedent implies the consequent in the next cycle.
`define ADQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// The expression never holds.
`define ADQ_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("assertion failed");

`endif

### rtl/adq_pkg.sv
// ----------------------------------------------------------------------------
// Array deque package
// Item types, opcodes and status codes of the array-based double-ended queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adq_pkg;

	localparam int DATA_W = 32;

	localparam logic [2:0] OP_INS_REAR  = 3'd0;
	localparam logic [2:0] OP_DEL_FRONT = 3'd1;
	localparam logic [2:0] OP_INS_FRONT = 3'd2;
	localparam logic [2:0] OP_DEL_REAR  = 3'd3;
	localparam logic [2:0] OP_DUMP      = 3'd4;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_OVERFLOW = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_REFUSED  = 2'd3;

	typedef struct packed {
		logic [2:0]               opcode;
		logic signed [DATA_W-1:0] item_value;
	} in_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] data_value;
		logic                     data_valid;
		logic                     last_of_run;
	} out_t;

endpackage

### rtl/array_double_ended_queue.sv
// ----------------------------------------------------------------------------
// Array double-ended queue
// Deque kept in a linear array of QUEUE_DEPTH entries with front and rear
// indices. Input items carry an opcode (insert rear, delete front, insert
// front, delete rear, dump) and a value; results carry a status, the removed
// or dumped value, a data flag and a last-of-run flag.
// Both channels are valid/ready. One item is worked on at a time: in_ready is
// high only while the sequencer is idle and no result is pending.
// Inserts: the result is registered in the cycle after accept. Deletes: the
// result passes through the registered memory read, then the output register.
// Dump: one result per stored entry, each through the memory read, then the
// output register, using the single memory read port and shared index adder.
// A stalled receiver holds the output register; nothing advances until the
// result is taken. Reset empties the queue at once; the entry memory is not
// cleared, and only written entries are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module array_double_ended_queue #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  adq_pkg::in_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output adq_pkg::out_t out_data
);
	import adq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam logic [AW:0] REAR_EMPTY = '1;
	localparam logic [AW:0] LAST_IDX = (AW+1)'(QUEUE_DEPTH - 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0]        state_q, state_d;
	logic [AW-1:0]     front_q, front_d;
	logic [AW:0]       rear_q, rear_d;
	logic [AW-1:0]     ptr_q, ptr_d;
	logic              dump_q, dump_d;
	out_t              out_q, res;
	logic              load_res;

	logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
	logic [DATA_W-1:0] rdata_q;
	logic              wr_en, rd_en;
	logic [AW-1:0]     wr_addr, rd_addr;

	// shared index adder: +1 or -1 on one index at a time
	logic [AW:0]       add_base, add_sum;
	logic              add_dec;

	logic              accept, empty;
	logic [AW-1:0]     rear_lo;

	assign add_sum  = add_base + (add_dec ? REAR_EMPTY : (AW+1)'(1));
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign empty    = (rear_q == REAR_EMPTY);
	assign rear_lo  = rear_q[AW-1:0];
	assign out_valid = (state_q == S_OUT);
	assign out_data  = out_q;

	always_comb begin
		state_d  = state_q;
		front_d  = front_q;
		rear_d   = rear_q;
		ptr_d    = ptr_q;
		dump_d   = dump_q;
		wr_en    = 1'b0;
		wr_addr  = front_q;
		rd_en    = 1'b0;
		rd_addr  = front_q;
		add_base = {1'b0, front_q};
		add_dec  = 1'b0;
		load_res = 1'b0;
		res      = '{status: ST_OK, data_value: '0, data_valid: 1'b0, last_of_run: 1'b1};

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					dump_d = 1'b0;
					unique case (in_data.opcode)
						OP_INS_REAR: begin
							add_base = rear_q;
							load_res = 1'b1;
							state_d  = S_OUT;
							if (!empty && rear_q == LAST_IDX) begin
								res.status = ST_OVERFLOW;
							end else begin
								rear_d  = add_sum;
								wr_en   = 1'b1;
								wr_addr = add_sum[AW-1:0];
							end
						end
						OP_DEL_FRONT: begin
							if (empty) begin
								res.status = ST_EMPTY;
								load_res   = 1'b1;
								state_d    = S_OUT;
							end else begin
								rd_en   = 1'b1;
								rd_addr = front_q;
								state_d = S_READ;
								if (front_q == rear_lo) begin
									front_d = '0;
									rear_d  = REAR_EMPTY;
								end else begin
									front_d = add_sum[AW-1:0];
								end
							end
						end
						OP_INS_FRONT: begin
							load_res = 1'b1;
							state_d  = S_OUT;
							add_dec  = 1'b1;
							if (front_q == '0 && !empty) begin
								res.status = ST_REFUSED;
							end else if (empty) begin
								rear_d  = '0;
								wr_en   = 1'b1;
								wr_addr = '0;
							end else begin
								front_d = add_sum[AW-1:0];
								wr_en   = 1'b1;
								wr_addr = add_sum[AW-1:0];
							end
						end
						OP_DEL_REAR: begin
							if (empty) begin
								res.status = ST_EMPTY;
								load_res   = 1'b1;
								state_d    = S_OUT;
							end else begin
								rd_en    = 1'b1;
								rd_addr  = rear_lo;
								add_base = rear_q;
								add_dec  = 1'b1;
								state_d  = S_READ;
								if (rear_lo == front_q) begin
									front_d = '0;
									rear_d  = REAR_EMPTY;
								end else begin
									rear_d = add_sum;
								end
							end
						end
						OP_DUMP: begin
							if (empty) begin
								res.status = ST_EMPTY;
								load_res   = 1'b1;
								state_d    = S_OUT;
							end else begin
								rd_en   = 1'b1;
								rd_addr = front_q;
								ptr_d   = front_q;
								dump_d  = 1'b1;
								state_d = S_READ;
							end
						end
						default: begin
							// unused opcodes: drop the item, no result
						end
					endcase
				end
			end
			S_READ: begin
				res.data_value  = rdata_q;
				res.data_valid  = 1'b1;
				res.last_of_run = dump_q ? (ptr_q == rear_lo) : 1'b1;
				load_res        = 1'b1;
				state_d         = S_OUT;
			end
			S_OUT: begin
				if (out_ready) begin
					if (dump_q && !out_q.last_of_run) begin
						// advance to the next stored entry
						add_base = {1'b0, ptr_q};
						ptr_d    = add_sum[AW-1:0];
						rd_en    = 1'b1;
						rd_addr  = add_sum[AW-1:0];
						state_d  = S_READ;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			rear_q  <= REAR_EMPTY;
			ptr_q   <= '0;
			dump_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			rear_q  <= rear_d;
			ptr_q   <= ptr_d;
			dump_q  <= dump_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= in_data.item_value;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/adq_checker.sv
// ----------------------------------------------------------------------------
// Array deque checker
// Port-level assertions for the array double-ended queue, bound to its top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module adq_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input adq_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input adq_pkg::out_t out_data
);
	import adq_pkg::*;

	// a pending result blocks new items
	`ADQ_ASSERT_NEVER(a_busy_while_out, clk, arst_n, in_ready && out_valid)

	`ADQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	`ADQ_ASSERT_IMPL(a_data_ok, clk, arst_n, out_valid && out_data.data_valid, out_data.status == ST_OK)

	`ADQ_ASSERT_IMPL(a_no_data_zero, clk, arst_n, out_valid && !out_data.data_valid, out_data.data_value == '0)

	// inserts answer in the next cycle with a single, data-less result
	`ADQ_ASSERT_NEXT(a_insert_result, clk, arst_n, in_valid && in_ready && (in_data.opcode == OP_INS_REAR || in_data.opcode == OP_INS_FRONT), out_valid && out_data.last_of_run && !out_data.data_valid)

endmodule

bind array_double_ended_queue adq_checker u_adq_checker (.*);
